@@ design/tc_pkg.sv @@
package tc_pkg;

	// quotient and result width, signed Q24.8
	localparam int Q_BITS = 32;

	localparam logic [Q_BITS-1:0] POS_LIMIT = {1'b0, {(Q_BITS-1){1'b1}}};
	localparam logic [Q_BITS-1:0] NEG_LIMIT = {1'b1, {(Q_BITS-1){1'b0}}};

	// result lanes: x and y
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;

endpackage

@@ design/tc_in_if.sv @@
interface tc_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_a_x;
	logic signed [COORD_BITS-1:0] vertex_a_y;
	logic signed [COORD_BITS-1:0] vertex_b_x;
	logic signed [COORD_BITS-1:0] vertex_b_y;
	logic signed [COORD_BITS-1:0] vertex_c_x;
	logic signed [COORD_BITS-1:0] vertex_c_y;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
		output ready
	);
	modport monitor (
		input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
		input  ready
	);
endinterface

@@ design/tc_out_if.sv @@
interface tc_out_if;
	import tc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [Q_BITS-1:0] center_x;
	logic signed [Q_BITS-1:0] center_y;
	logic                     degenerate;
	logic                     saturated;

	modport source (
		output valid, center_x, center_y, degenerate, saturated,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, degenerate, saturated,
		output ready
	);
	modport monitor (
		input  valid, center_x, center_y, degenerate, saturated,
		input  ready
	);
endinterface

@@ design/triangle_circumcenter.sv @@
// Circumcenter of a planar triangle, one triangle per transaction.
// vertices: valid/ready channel carrying the three vertices as signed
//   Q8.8 coordinates (COORD_BITS wide).
// center: valid/ready channel carrying center_x and center_y as signed
//   Q24.8, rounded toward zero and clipped, with a saturated flag and a
//   degenerate flag for collinear vertices (centers then zero).
// Throughput: one triangle per cycle, fully pipelined, unless the output stalls.
// Pipeline: from acceptance to the result being offered there are three
//   stages for differences and squares, products, and sums, one for
//   magnitudes, one for the overflow check, 32 for the restoring divider
//   (one quotient bit per stage, one for each lane) and one output register.
// The 32 divider stages set the latency; the squares are multiplied in
//   stage 1 and the products in their own stage, with a register after each.
// Reset clears every valid bit; no result is offered until a triangle has
//   passed through.
// When the receiver holds ready low while a result is offered, the whole
//   pipeline holds and vertices.ready drops; nothing is lost or repeated.
module triangle_circumcenter #(
	parameter int COORD_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	tc_in_if.sink   vertices,
	tc_out_if.source center
);
	import tc_pkg::*;

	localparam int W    = COORD_BITS;
	localparam int DFW  = W + 1;
	localparam int SQW  = 2 * W;
	localparam int PDW  = 2 * W + 1;
	localparam int PNW  = 3 * W + 2;
	localparam int NW   = 3 * W + 4;
	localparam int DW   = 2 * W + 4;
	localparam int MNW  = (NW > Q_BITS) ? NW : Q_BITS + 1;
	localparam int TW   = MNW - Q_BITS;
	localparam int CW   = (TW > DW) ? TW : DW;
	localparam int NSTG = Q_BITS;

	logic en;
	assign en             = !center.valid || center.ready;
	assign vertices.ready = en;

	// stage 1: differences and squared norms
	logic [W-1:0] ma_x, ma_y, mb_x, mb_y, mc_x, mc_y;
	assign ma_x = vertices.vertex_a_x[W-1] ? W'(-vertices.vertex_a_x) : vertices.vertex_a_x;
	assign ma_y = vertices.vertex_a_y[W-1] ? W'(-vertices.vertex_a_y) : vertices.vertex_a_y;
	assign mb_x = vertices.vertex_b_x[W-1] ? W'(-vertices.vertex_b_x) : vertices.vertex_b_x;
	assign mb_y = vertices.vertex_b_y[W-1] ? W'(-vertices.vertex_b_y) : vertices.vertex_b_y;
	assign mc_x = vertices.vertex_c_x[W-1] ? W'(-vertices.vertex_c_x) : vertices.vertex_c_x;
	assign mc_y = vertices.vertex_c_y[W-1] ? W'(-vertices.vertex_c_y) : vertices.vertex_c_y;

	logic                  v_s1;
	logic signed [W-1:0]   ax_s1, bx_s1, cx_s1;
	logic signed [DFW-1:0] dy_bc_s1, dy_ca_s1, dy_ab_s1, dx_cb_s1, dx_ac_s1, dx_ba_s1;
	logic [SQW-1:0]        sa_s1, sb_s1, sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vertices.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= vertices.vertex_a_x;
			bx_s1    <= vertices.vertex_b_x;
			cx_s1    <= vertices.vertex_c_x;
			dy_bc_s1 <= DFW'(vertices.vertex_b_y) - DFW'(vertices.vertex_c_y);
			dy_ca_s1 <= DFW'(vertices.vertex_c_y) - DFW'(vertices.vertex_a_y);
			dy_ab_s1 <= DFW'(vertices.vertex_a_y) - DFW'(vertices.vertex_b_y);
			dx_cb_s1 <= DFW'(vertices.vertex_c_x) - DFW'(vertices.vertex_b_x);
			dx_ac_s1 <= DFW'(vertices.vertex_a_x) - DFW'(vertices.vertex_c_x);
			dx_ba_s1 <= DFW'(vertices.vertex_b_x) - DFW'(vertices.vertex_a_x);
			sa_s1    <= SQW'(ma_x) * SQW'(ma_x) + SQW'(ma_y) * SQW'(ma_y);
			sb_s1    <= SQW'(mb_x) * SQW'(mb_x) + SQW'(mb_y) * SQW'(mb_y);
			sc_s1    <= SQW'(mc_x) * SQW'(mc_x) + SQW'(mc_y) * SQW'(mc_y);
		end
	end

	// stage 2: products
	logic                  v_s2;
	logic signed [PDW-1:0] pd_a_s2, pd_b_s2, pd_c_s2;
	logic signed [PNW-1:0] px_a_s2, px_b_s2, px_c_s2, py_a_s2, py_b_s2, py_c_s2;
	logic signed [PNW-1:0] sa_e, sb_e, sc_e;

	assign sa_e = $signed(PNW'(sa_s1));
	assign sb_e = $signed(PNW'(sb_s1));
	assign sc_e = $signed(PNW'(sc_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_a_s2 <= PDW'(ax_s1) * PDW'(dy_bc_s1);
			pd_b_s2 <= PDW'(bx_s1) * PDW'(dy_ca_s1);
			pd_c_s2 <= PDW'(cx_s1) * PDW'(dy_ab_s1);
			px_a_s2 <= sa_e * PNW'(dy_bc_s1);
			px_b_s2 <= sb_e * PNW'(dy_ca_s1);
			px_c_s2 <= sc_e * PNW'(dy_ab_s1);
			py_a_s2 <= sa_e * PNW'(dx_cb_s1);
			py_b_s2 <= sb_e * PNW'(dx_ac_s1);
			py_c_s2 <= sc_e * PNW'(dx_ba_s1);
		end
	end

	// stage 3: sums
	logic                 v_s3;
	logic signed [DW-1:0] den_s3;
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic signed [DW-1:0] den_half;

	assign den_half = DW'(pd_a_s2) + DW'(pd_b_s2) + DW'(pd_c_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= den_half <<< 1;
			nx_s3  <= NW'(px_a_s2) + NW'(px_b_s2) + NW'(px_c_s2);
			ny_s3  <= NW'(py_a_s2) + NW'(py_b_s2) + NW'(py_c_s2);
		end
	end

	// stage 4: magnitudes and quotient signs
	logic            v_s4;
	logic            degen_s4;
	logic [DW-1:0]   dmag_s4;
	logic [MNW-1:0]  nmag_s4 [0:1];
	logic            neg_s4  [0:1];
	logic [NW-1:0]   nx_abs, ny_abs;

	assign nx_abs = nx_s3[NW-1] ? NW'(-nx_s3) : nx_s3;
	assign ny_abs = ny_s3[NW-1] ? NW'(-ny_s3) : ny_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s4        <= (den_s3 == '0);
			dmag_s4         <= den_s3[DW-1] ? DW'(-den_s3) : den_s3;
			nmag_s4[LANE_X] <= MNW'(nx_abs);
			nmag_s4[LANE_Y] <= MNW'(ny_abs);
			neg_s4[LANE_X]  <= nx_s3[NW-1] ^ den_s3[DW-1];
			neg_s4[LANE_Y]  <= ny_s3[NW-1] ^ den_s3[DW-1];
		end
	end

	// divider: entry 0 is the overflow check stage, then one quotient bit per stage
	logic              dv_v_s     [0:NSTG];
	logic              dv_degen_s [0:NSTG];
	logic [DW-1:0]     dv_dmag_s  [0:NSTG];
	logic [DW-1:0]     dv_rem_s   [0:1][0:NSTG];
	logic [Q_BITS-1:0] dv_low_s   [0:1][0:NSTG];
	logic [Q_BITS-1:0] dv_quo_s   [0:1][0:NSTG];
	logic              dv_ovf_s   [0:1][0:NSTG];
	logic              dv_neg_s   [0:1][0:NSTG];

	logic [DW:0]       trial      [0:1][0:NSTG-1];
	logic [TW-1:0]     top        [0:1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			top[l] = nmag_s4[l][MNW-1:Q_BITS];
			for (int k = 0; k < NSTG; k++) begin
				trial[l][k] = {dv_rem_s[l][k], dv_low_s[l][k][Q_BITS-1]}
				              - {1'b0, dv_dmag_s[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTG; k++) begin
				dv_v_s[k] <= 1'b0;
			end
		end else if (en) begin
			dv_v_s[0] <= v_s4;
			for (int k = 1; k <= NSTG; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_degen_s[0] <= degen_s4;
			dv_dmag_s[0]  <= dmag_s4;
			for (int l = 0; l < 2; l++) begin
				// a quotient of 2^32 or more shows as the top part reaching the divisor
				dv_ovf_s[l][0] <= (CW'(top[l]) >= CW'(dmag_s4));
				dv_rem_s[l][0] <= DW'(top[l]);
				dv_low_s[l][0] <= nmag_s4[l][Q_BITS-1:0];
				dv_quo_s[l][0] <= '0;
				dv_neg_s[l][0] <= neg_s4[l];
			end
			for (int k = 1; k <= NSTG; k++) begin
				dv_degen_s[k] <= dv_degen_s[k-1];
				dv_dmag_s[k]  <= dv_dmag_s[k-1];
				for (int l = 0; l < 2; l++) begin
					dv_ovf_s[l][k] <= dv_ovf_s[l][k-1];
					dv_neg_s[l][k] <= dv_neg_s[l][k-1];
					dv_low_s[l][k] <= dv_low_s[l][k-1] << 1;
					if (!trial[l][k-1][DW]) begin
						dv_rem_s[l][k] <= trial[l][k-1][DW-1:0];
						dv_quo_s[l][k] <= {dv_quo_s[l][k-1][Q_BITS-2:0], 1'b1};
					end else begin
						dv_rem_s[l][k] <= {dv_rem_s[l][k-1][DW-2:0],
						                   dv_low_s[l][k-1][Q_BITS-1]};
						dv_quo_s[l][k] <= {dv_quo_s[l][k-1][Q_BITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	// output stage: sign, clip, degenerate override
	logic [Q_BITS-1:0] res  [0:1];
	logic              clip [0:1];
	logic [Q_BITS-1:0] lim;
	logic [Q_BITS-1:0] q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			q       = dv_quo_s[l][NSTG];
			lim     = dv_neg_s[l][NSTG] ? NEG_LIMIT : POS_LIMIT;
			clip[l] = dv_ovf_s[l][NSTG] || (q > lim);
			if (clip[l]) begin
				res[l] = lim;
			end else begin
				res[l] = dv_neg_s[l][NSTG] ? Q_BITS'(-q) : q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center.valid <= 1'b0;
		end else if (en) begin
			center.valid <= dv_v_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_degen_s[NSTG]) begin
				center.center_x   <= '0;
				center.center_y   <= '0;
				center.degenerate <= 1'b1;
				center.saturated  <= 1'b0;
			end else begin
				center.center_x   <= res[LANE_X];
				center.center_y   <= res[LANE_Y];
				center.degenerate <= 1'b0;
				center.saturated  <= clip[LANE_X] || clip[LANE_Y];
			end
		end
	end

endmodule
